>>> rtl/trcc_pkg.sv
// Shared types and constants for the TLV replay counter check.
// Holds the verdict codes, register indexes and counter record sizes.
// No dependencies.
package trcc_pkg;

    localparam int COUNTER_BYTES = 6;
    localparam int VALUE_W       = 8 * COUNTER_BYTES;
    localparam int BYTE_W        = 8;
    localparam int SLOT_IN_W     = 4;
    localparam int BLEFT_W       = 8;
    localparam int VIDX_W        = 3;
    localparam int SEEN_W        = 2;

    typedef enum logic [1:0] {
        VERDICT_ACCEPT    = 2'd0,
        VERDICT_REPLAY    = 2'd1,
        VERDICT_COUNT     = 2'd2,
        VERDICT_MALFORMED = 2'd3
    } verdict_t;

    typedef enum logic {
        CFG_PAD_TYPE     = 1'b0,
        CFG_COUNTER_TYPE = 1'b1
    } cfg_index_t;

    localparam logic [BYTE_W-1:0] PAD_TYPE_RESET     = 8'd0;
    localparam logic [BYTE_W-1:0] COUNTER_TYPE_RESET = 8'd11;

endpackage

>>> rtl/tlv_replay_counter_check.sv
// Top level of the TLV replay counter check: record parser, counter compare
// and the per-neighbour counter memory. Depends on trcc_pkg.
//
//   channel   | signals                                        | handshake
//   ----------+------------------------------------------------+-----------------
//   body in   | neighbour_slot, body_byte, last_byte           | body_valid/ready
//   verdict   | verdict                                        | verdict_valid/ready
//   config    | cfg_index, cfg_data                            | cfg_write_en
//
// One byte is taken per cycle; the parser, the byte compare and the memory
// write all finish in the cycle the byte transfers. The counter memory is read
// once per packet, on its first byte, and the value is needed no earlier than
// the third byte; counters committed inside the packet are forwarded from a
// local register. Reset clears one valid bit per memory entry, so there is no
// clearing pass. Body bytes that are not last bytes are always taken; a last
// byte waits only while a previous verdict still sits unclaimed in the output
// register.
module tlv_replay_counter_check
    import trcc_pkg::*;
#(
    parameter int NEIGHBOURS = 16
)(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_write_en,
    input  logic                 cfg_index,
    input  logic [BYTE_W-1:0]    cfg_data,

    input  logic                 body_valid,
    output logic                 body_ready,
    input  logic [SLOT_IN_W-1:0] neighbour_slot,
    input  logic [BYTE_W-1:0]    body_byte,
    input  logic                 last_byte,

    output logic                 verdict_valid,
    input  logic                 verdict_ready,
    output logic [1:0]           verdict
);

    localparam int SLOT_W = (NEIGHBOURS > 1) ? $clog2(NEIGHBOURS) : 1;

    typedef enum logic [1:0] {
        PH_TYPE,
        PH_LENGTH,
        PH_SKIP,
        PH_VALUE
    } phase_t;

    typedef enum logic [1:0] {
        CMP_EQUAL,
        CMP_GREATER,
        CMP_LESS
    } cmp_t;

    // Configuration registers
    logic [BYTE_W-1:0] pad_code_reg;
    logic [BYTE_W-1:0] ctr_code_reg;

    // Per-packet parser state
    phase_t               phase_reg,   phase_next;
    logic [BLEFT_W-1:0]   bleft_reg,   bleft_next;
    logic [VIDX_W-1:0]    vidx_reg,    vidx_next;
    cmp_t                 cmp_reg,     cmp_next;
    logic [VALUE_W-1:0]   staged_reg,  staged_next;
    logic [SEEN_W-1:0]    seen_reg,    seen_next;
    verdict_t             pverd_reg,   pverd_next;
    logic                 ctrrec_reg,  ctrrec_next;
    logic                 in_pkt_reg;
    logic [SLOT_W-1:0]    slot_reg;

    // Current view: cleared values on the first byte of a packet
    phase_t               cur_phase;
    logic [BLEFT_W-1:0]   cur_bleft;
    logic [VIDX_W-1:0]    cur_vidx;
    cmp_t                 cur_cmp;
    logic [VALUE_W-1:0]   cur_staged;
    logic [SEEN_W-1:0]    cur_seen;
    verdict_t             cur_pverd;
    logic                 cur_ctrrec;

    // Counter memory, its valid bits and the forwarding register
    logic [VALUE_W-1:0]   counter_mem [NEIGHBOURS];
    logic [NEIGHBOURS-1:0] entry_valid_reg;
    logic [VALUE_W-1:0]   rd_data_reg;
    logic                 rd_valid_reg;
    logic [VALUE_W-1:0]   fwd_value_reg;
    logic                 fwd_valid_reg;
    logic [VALUE_W-1:0]   stored_value;

    logic                 body_xfer;
    logic                 first_byte;
    logic [SLOT_W-1:0]    slot_in;
    logic [VIDX_W-1:0]    byte_sel;
    logic [BYTE_W-1:0]    old_byte;
    logic                 commit;
    verdict_t             result;

    // Output register
    logic                 out_valid_reg;
    verdict_t             out_verdict_reg;

    assign body_ready = !last_byte || !out_valid_reg || verdict_ready;
    assign body_xfer  = body_valid && body_ready;
    assign first_byte = !in_pkt_reg;

    // Fold the incoming slot onto the memory depth with a small constant table
    always_comb
    begin
        slot_in = '0;
        for (int i = 0; i < (1 << SLOT_IN_W); i++)
        begin
            if (neighbour_slot == SLOT_IN_W'(i))
            begin
                slot_in = SLOT_W'(i % NEIGHBOURS);
            end
        end
    end

    assign verdict_valid = out_valid_reg;
    assign verdict       = out_verdict_reg;

    // Counter of this packet: committed value first, then the memory read
    assign stored_value = fwd_valid_reg ? fwd_value_reg :
                          (rd_valid_reg ? rd_data_reg : '0);
    assign byte_sel     = VIDX_W'(COUNTER_BYTES - 1) - cur_vidx;
    assign old_byte     = stored_value[{byte_sel, 3'b000} +: BYTE_W];

    always_comb
    begin
        if (first_byte)
        begin
            cur_phase  = PH_TYPE;
            cur_bleft  = '0;
            cur_vidx   = '0;
            cur_cmp    = CMP_EQUAL;
            cur_staged = '0;
            cur_seen   = '0;
            cur_pverd  = VERDICT_ACCEPT;
            cur_ctrrec = 1'b0;
        end
        else
        begin
            cur_phase  = phase_reg;
            cur_bleft  = bleft_reg;
            cur_vidx   = vidx_reg;
            cur_cmp    = cmp_reg;
            cur_staged = staged_reg;
            cur_seen   = seen_reg;
            cur_pverd  = pverd_reg;
            cur_ctrrec = ctrrec_reg;
        end

        phase_next  = cur_phase;
        bleft_next  = cur_bleft;
        vidx_next   = cur_vidx;
        cmp_next    = cur_cmp;
        staged_next = cur_staged;
        seen_next   = cur_seen;
        pverd_next  = cur_pverd;
        ctrrec_next = cur_ctrrec;
        commit      = 1'b0;

        // A rejected packet ignores everything up to its last byte
        if (cur_pverd == VERDICT_ACCEPT)
        begin
            unique case (cur_phase)
                PH_TYPE:
                begin
                    if (body_byte != pad_code_reg)
                    begin
                        ctrrec_next = (body_byte == ctr_code_reg);
                        phase_next  = PH_LENGTH;
                    end
                end
                PH_LENGTH:
                begin
                    if (cur_ctrrec)
                    begin
                        if (body_byte < BYTE_W'(COUNTER_BYTES))
                        begin
                            pverd_next = VERDICT_MALFORMED;
                        end
                        else
                        begin
                            bleft_next  = body_byte;
                            vidx_next   = '0;
                            cmp_next    = CMP_EQUAL;
                            staged_next = '0;
                            phase_next  = PH_VALUE;
                            ctrrec_next = 1'b0;
                        end
                    end
                    else
                    begin
                        bleft_next  = body_byte;
                        phase_next  = (body_byte == '0) ? PH_TYPE : PH_SKIP;
                        ctrrec_next = 1'b0;
                    end
                end
                PH_SKIP:
                begin
                    bleft_next = cur_bleft - 1'b1;
                    if (bleft_next == '0)
                    begin
                        phase_next = PH_TYPE;
                    end
                end
                PH_VALUE:
                begin
                    // Big-endian compare: the first differing byte decides
                    if (cur_cmp == CMP_EQUAL)
                    begin
                        if (body_byte > old_byte)
                        begin
                            cmp_next = CMP_GREATER;
                        end
                        else if (body_byte < old_byte)
                        begin
                            cmp_next = CMP_LESS;
                        end
                    end
                    staged_next = {cur_staged[VALUE_W-BYTE_W-1:0], body_byte};
                    bleft_next  = cur_bleft - 1'b1;
                    vidx_next   = cur_vidx + 1'b1;
                    if (vidx_next >= VIDX_W'(COUNTER_BYTES))
                    begin
                        vidx_next = '0;
                        if (cmp_next != CMP_GREATER)
                        begin
                            pverd_next = VERDICT_REPLAY;
                        end
                        else
                        begin
                            commit = 1'b1;
                            if (cur_seen < SEEN_W'(2))
                            begin
                                seen_next = cur_seen + 1'b1;
                            end
                            phase_next = (bleft_next == '0) ? PH_TYPE : PH_SKIP;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_TYPE;
                end
            endcase
        end

        // Verdict reported on the last byte
        priority if (pverd_next != VERDICT_ACCEPT)
        begin
            result = pverd_next;
        end
        else if (phase_next == PH_VALUE || (phase_next == PH_LENGTH && ctrrec_next))
        begin
            result = VERDICT_MALFORMED;
        end
        else if (seen_next != SEEN_W'(1))
        begin
            result = VERDICT_COUNT;
        end
        else
        begin
            result = VERDICT_ACCEPT;
        end
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pad_code_reg <= PAD_TYPE_RESET;
            ctr_code_reg <= COUNTER_TYPE_RESET;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_PAD_TYPE:     pad_code_reg <= cfg_data;
                CFG_COUNTER_TYPE: ctr_code_reg <= cfg_data;
                default:          pad_code_reg <= pad_code_reg;
            endcase
        end
    end

    // Parser state: advance on every transfer, drop back to clear on the last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_TYPE;
            bleft_reg  <= '0;
            vidx_reg   <= '0;
            cmp_reg    <= CMP_EQUAL;
            staged_reg <= '0;
            seen_reg   <= '0;
            pverd_reg  <= VERDICT_ACCEPT;
            ctrrec_reg <= 1'b0;
            in_pkt_reg <= 1'b0;
            slot_reg   <= '0;
        end
        else if (body_xfer)
        begin
            if (first_byte)
            begin
                slot_reg <= slot_in;
            end
            phase_reg  <= phase_next;
            bleft_reg  <= bleft_next;
            vidx_reg   <= vidx_next;
            cmp_reg    <= cmp_next;
            staged_reg <= staged_next;
            seen_reg   <= seen_next;
            pverd_reg  <= pverd_next;
            ctrrec_reg <= ctrrec_next;
            in_pkt_reg <= !last_byte;
        end
    end

    // Counter memory: one read per packet, one write per committed record
    always_ff @(posedge clk)
    begin
        if (body_xfer && commit)
        begin
            counter_mem[slot_reg] <= staged_next;
        end
        if (body_xfer && first_byte)
        begin
            rd_data_reg <= counter_mem[slot_in];
        end
    end

    // Entry valid bits and forwarding of values committed within the packet
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= '0;
            rd_valid_reg    <= 1'b0;
            fwd_valid_reg   <= 1'b0;
            fwd_value_reg   <= '0;
        end
        else if (body_xfer)
        begin
            if (first_byte)
            begin
                rd_valid_reg  <= entry_valid_reg[slot_in];
                fwd_valid_reg <= 1'b0;
            end
            if (commit)
            begin
                entry_valid_reg[slot_reg] <= 1'b1;
                fwd_valid_reg             <= 1'b1;
                fwd_value_reg             <= staged_next;
            end
        end
    end

    // Output register: load on a last-byte transfer, hold until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            out_verdict_reg <= VERDICT_ACCEPT;
        end
        else if (body_xfer && last_byte)
        begin
            out_valid_reg   <= 1'b1;
            out_verdict_reg <= result;
        end
        else if (verdict_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

endmodule

>>> rtl/trcc_checker.sv
// Port-level checks for tlv_replay_counter_check, with the bind that attaches them.
// Sees only the top-level ports; no package dependency.
module trcc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       body_valid,
    input logic       body_ready,
    input logic       last_byte,
    input logic       verdict_valid,
    input logic       verdict_ready,
    input logic [1:0] verdict
);

    // Hold a stalled verdict
    assert property (@(posedge clk) disable iff (!rst_n)
        verdict_valid && !verdict_ready |=> verdict_valid && $stable(verdict))
        else $error("verdict changed or dropped while stalled");

    // Every last-byte transfer yields a verdict in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        body_valid && body_ready && last_byte |=> verdict_valid)
        else $error("last byte transferred without a verdict");

    // Never overwrite an unclaimed verdict
    assert property (@(posedge clk) disable iff (!rst_n)
        verdict_valid && !verdict_ready && last_byte |-> !body_ready)
        else $error("last byte taken while verdict pending");

    // A verdict appears only after a last-byte transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(verdict_valid) |-> $past(body_valid && body_ready && last_byte))
        else $error("verdict without a last byte");

endmodule

bind tlv_replay_counter_check trcc_checker u_trcc_checker (.*);

>>> tb/tlv_replay_counter_check_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for tlv_replay_counter_check: feeds packet bodies byte by
// byte and checks each verdict against an in-bench predictor. Depends on trcc_pkg.
module tlv_replay_counter_check_test;
    import trcc_pkg::*;

    localparam int               NEIGHBOURS  = 16;
    localparam int               DRAIN_WAIT  = 4;
    localparam logic [VALUE_W-1:0] CTR_MAX   = '1;

    // Walk position inside the TLV records of the current packet.
    typedef enum logic [1:0] {
        PH_TYPE,
        PH_LEN,
        PH_SKIP,
        PH_VALUE
    } parse_phase_t;

    // Running big-endian comparison of the new counter against the stored one.
    typedef enum logic [1:0] {
        CMP_EQ,
        CMP_GT,
        CMP_LT
    } cmp_t;

    typedef struct packed {
        logic [SLOT_IN_W-1:0] slot;
        logic [BYTE_W-1:0]    data;
        logic                 last;
    } body_xfer_t;

    typedef logic [BYTE_W-1:0] byte_list_t[$];

    logic                 clk            = 1'b0;
    logic                 rst_n          = 1'b0;
    logic                 cfg_write_en   = 1'b0;
    logic                 cfg_index      = 1'b0;
    logic [BYTE_W-1:0]    cfg_data       = '0;
    logic                 body_valid     = 1'b0;
    logic                 body_ready;
    logic [SLOT_IN_W-1:0] neighbour_slot = '0;
    logic [BYTE_W-1:0]    body_byte      = '0;
    logic                 last_byte      = 1'b0;
    logic                 verdict_valid;
    logic                 verdict_ready  = 1'b0;
    logic [1:0]           verdict;

    tlv_replay_counter_check #(
        .NEIGHBOURS (NEIGHBOURS)
    ) u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .body_valid     (body_valid),
        .body_ready     (body_ready),
        .neighbour_slot (neighbour_slot),
        .body_byte      (body_byte),
        .last_byte      (last_byte),
        .verdict_valid  (verdict_valid),
        .verdict_ready  (verdict_ready),
        .verdict        (verdict)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor state: its own copy of the counter memory, the parser and
    // the two type-code registers.
    // ------------------------------------------------------------------
    logic [VALUE_W-1:0]   ctr_mem [NEIGHBOURS];
    parse_phase_t         parse_phase;
    logic [BLEFT_W-1:0]   skip_count;
    logic [VIDX_W-1:0]    val_pos;
    cmp_t                 cmp;
    logic [VALUE_W-1:0]   new_ctr;
    logic [SEEN_W-1:0]    ctr_count;
    verdict_t             pkt_verdict;
    logic [SLOT_IN_W-1:0] pkt_slot;
    logic                 mid_packet;
    logic                 len_is_ctr;
    logic [BYTE_W-1:0]    reg_pad;
    logic [BYTE_W-1:0]    reg_ctr;

    // Verdicts owed by the block, oldest first.
    verdict_t             verdicts_due[$];

    // Stimulus side: pending body bytes and the generator's view of the
    // highest counter handed out per slot.
    body_xfer_t           body_pending[$];
    body_xfer_t           next_xfer;
    byte_list_t           pkt_bytes;
    logic [VALUE_W-1:0]   gen_last [NEIGHBOURS];

    logic                 body_moved    = 1'b0;
    int                   send_idle_pct = 32;
    int                   rcv_idle_pct  = 32;
    int                   hold_req      = 0;
    int                   hold_left     = 0;

    int                   fail_count    = 0;
    int                   mismatch_seen = 0;
    int                   bytes_moved   = 0;
    int                   settings_used = 1;
    int                   verdict_seen [4];

    task automatic restart_packet();
        parse_phase = PH_TYPE;
        skip_count  = '0;
        val_pos     = '0;
        cmp         = CMP_EQ;
        new_ctr     = '0;
        ctr_count   = '0;
        pkt_verdict = VERDICT_ACCEPT;
        len_is_ctr  = 1'b0;
    endtask

    task automatic reset_model();
        for (int i = 0; i < NEIGHBOURS; i++)
        begin
            ctr_mem[i]  = '0;
            gen_last[i] = '0;
        end
        restart_packet();
        pkt_slot   = '0;
        mid_packet = 1'b0;
        reg_pad    = PAD_TYPE_RESET;
        reg_ctr    = COUNTER_TYPE_RESET;
    endtask

    // Advance the predictor by one transferred body byte; on a last byte,
    // queue the verdict the block owes for the packet.
    task automatic track_body_byte(input logic [SLOT_IN_W-1:0] slot,
                                   input logic [BYTE_W-1:0] b, input logic last);
        logic [BYTE_W-1:0] old_b;
        verdict_t          v;
        if (!mid_packet)
        begin
            restart_packet();
            pkt_slot   = slot;
            mid_packet = 1'b1;
        end
        if (pkt_verdict == VERDICT_ACCEPT)
        begin
            case (parse_phase)
                PH_TYPE:
                begin
                    if (b != reg_pad)
                    begin
                        len_is_ctr  = (b == reg_ctr);
                        parse_phase = PH_LEN;
                    end
                end
                PH_LEN:
                begin
                    if (len_is_ctr && b < COUNTER_BYTES)
                    begin
                        // short counter record: the packet is dead from here
                        pkt_verdict = VERDICT_MALFORMED;
                    end
                    else if (len_is_ctr)
                    begin
                        skip_count  = b;
                        val_pos     = '0;
                        cmp         = CMP_EQ;
                        new_ctr     = '0;
                        parse_phase = PH_VALUE;
                        len_is_ctr  = 1'b0;
                    end
                    else
                    begin
                        skip_count  = b;
                        parse_phase = (b == 0) ? PH_TYPE : PH_SKIP;
                    end
                end
                PH_SKIP:
                begin
                    skip_count = skip_count - 1'b1;
                    if (skip_count == 0)
                        parse_phase = PH_TYPE;
                end
                PH_VALUE:
                begin
                    old_b = ctr_mem[pkt_slot][8 * (COUNTER_BYTES - 1 - val_pos) +: 8];
                    if (cmp == CMP_EQ)
                    begin
                        if (b > old_b)
                            cmp = CMP_GT;
                        else if (b < old_b)
                            cmp = CMP_LT;
                    end
                    new_ctr    = {new_ctr[VALUE_W-9:0], b};
                    skip_count = skip_count - 1'b1;
                    val_pos    = val_pos + 1'b1;
                    if (val_pos == COUNTER_BYTES)
                    begin
                        val_pos = '0;
                        if (cmp != CMP_GT)
                            pkt_verdict = VERDICT_REPLAY;
                        else
                        begin
                            // commit at once so a later record in this packet sees it
                            ctr_mem[pkt_slot] = new_ctr;
                            if (ctr_count < 2)
                                ctr_count = ctr_count + 1'b1;
                            parse_phase = (skip_count == 0) ? PH_TYPE : PH_SKIP;
                        end
                    end
                end
            endcase
        end
        if (last)
        begin
            if (pkt_verdict != VERDICT_ACCEPT)
                v = pkt_verdict;
            else if (parse_phase == PH_VALUE || (parse_phase == PH_LEN && len_is_ctr))
                v = VERDICT_MALFORMED;
            else if (ctr_count != 1)
                v = VERDICT_COUNT;
            else
                v = VERDICT_ACCEPT;
            verdicts_due.push_back(v);
            restart_packet();
            mid_packet = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------
    // Body driver: launch a new byte at the falling edge once the previous
    // one has transferred; hold valid and payload until then.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n && (!body_valid || body_moved))
        begin
            body_moved = 1'b0;
            if (body_pending.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                next_xfer = body_pending.pop_front();
                body_valid     <= 1'b1;
                neighbour_slot <= next_xfer.slot;
                body_byte      <= next_xfer.data;
                last_byte      <= next_xfer.last;
            end
            else
                body_valid <= 1'b0;
        end
    end

    // Verdict receiver: a requested hold-off drops ready for that many
    // cycles, otherwise ready toggles at random.
    always @(negedge clk)
    begin
        if (hold_req != 0)
        begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left != 0)
        begin
            hold_left = hold_left - 1;
            verdict_ready <= 1'b0;
        end
        else
            verdict_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    // Monitor: at each rising edge, feed a body transfer to the predictor and
    // check a verdict transfer against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (body_valid && body_ready)
            begin
                track_body_byte(neighbour_slot, body_byte, last_byte);
                body_moved  = 1'b1;
                bytes_moved = bytes_moved + 1;
            end
            if (verdict_valid && verdict_ready)
            begin
                if (verdicts_due.size() == 0)
                begin
                    fail_count = fail_count + 1;
                    if (mismatch_seen < 10)
                        $display("ERROR %0t: verdict %0d with none expected", $realtime,
                                 verdict);
                    mismatch_seen = mismatch_seen + 1;
                end
                else
                begin
                    if (verdict !== verdicts_due[0])
                    begin
                        fail_count = fail_count + 1;
                        if (mismatch_seen < 10)
                            $display("ERROR %0t: verdict expected %0d got %0d", $realtime,
                                     verdicts_due[0], verdict);
                        mismatch_seen = mismatch_seen + 1;
                    end
                    verdict_seen[verdicts_due[0]] = verdict_seen[verdicts_due[0]] + 1;
                    void'(verdicts_due.pop_front());
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Move the bytes built so far into the pending queue as one packet.
    task automatic queue_bytes(input logic [SLOT_IN_W-1:0] slot);
        int n;
        n = pkt_bytes.size();
        for (int i = 0; i < n; i++)
            body_pending.push_back(body_xfer_t'{slot: slot, data: pkt_bytes[i],
                                                last: (i == n - 1)});
        pkt_bytes.delete();
    endtask

    // Append one counter record: mostly a newer value, sometimes equal,
    // older or arbitrary, with the odd short or oversized length.
    task automatic add_counter_record(input logic [SLOT_IN_W-1:0] slot);
        logic [VALUE_W-1:0] val;
        logic [VALUE_W-1:0] inc;
        int                 len;
        int                 r;
        r = $urandom_range(99);
        if (r < 80)
            len = COUNTER_BYTES;
        else if (r < 90)
            len = $urandom_range(COUNTER_BYTES + 1, 12);
        else if (r < 99)
            len = $urandom_range(0, COUNTER_BYTES - 1);
        else
            len = 255;
        r = $urandom_range(99);
        if (r < 75)
        begin
            inc = VALUE_W'($urandom_range(1, 255)) << (8 * $urandom_range(0, 4));
            if (gen_last[slot] > CTR_MAX - inc)
                val = CTR_MAX;
            else
                val = gen_last[slot] + inc;
        end
        else if (r < 85)
            val = gen_last[slot];
        else if (r < 93)
            val = (gen_last[slot] > 1000) ? gen_last[slot] - VALUE_W'($urandom_range(1, 1000))
                                          : '0;
        else
            val = VALUE_W'($urandom_range(0, 1 << 20));
        if (val > gen_last[slot])
            gen_last[slot] = val;
        pkt_bytes.push_back(reg_ctr);
        pkt_bytes.push_back(BYTE_W'(len));
        if (len >= COUNTER_BYTES)
        begin
            for (int k = COUNTER_BYTES - 1; k >= 0; k--)
                pkt_bytes.push_back(val[8 * k +: 8]);
            repeat (len - COUNTER_BYTES)
                pkt_bytes.push_back(BYTE_W'($urandom));
        end
    endtask

    // Append a pad byte or an ordinary record that the parser skips.
    task automatic add_other_record();
        int                t;
        int                len;
        int                r;
        if ($urandom_range(99) < 30)
            pkt_bytes.push_back(reg_pad);
        else
        begin
            do
                t = $urandom_range(255);
            while (t == reg_pad || t == reg_ctr);
            r = $urandom_range(99);
            if (r < 85)
                len = $urandom_range(0, 4);
            else if (r < 99)
                len = $urandom_range(5, 20);
            else
                len = 255;
            pkt_bytes.push_back(BYTE_W'(t));
            pkt_bytes.push_back(BYTE_W'(len));
            repeat (len)
                pkt_bytes.push_back(BYTE_W'($urandom));
        end
    endtask

    // Build one random packet: mostly well-formed record lists holding one
    // counter record, some with none or two, some cut short, some noise.
    task automatic queue_packet(output int n_bytes);
        logic [SLOT_IN_W-1:0] slot;
        int                   n_rec;
        int                   ctr_at;
        int                   ctr_also;
        int                   cut;
        int                   r;
        slot = SLOT_IN_W'($urandom_range(NEIGHBOURS - 1));
        if ($urandom_range(99) < 10)
        begin
            repeat ($urandom_range(1, 12))
            begin
                r = $urandom_range(5);
                if (r < 2)
                    pkt_bytes.push_back(reg_ctr);
                else if (r == 2)
                    pkt_bytes.push_back(reg_pad);
                else
                    pkt_bytes.push_back(BYTE_W'($urandom));
            end
        end
        else
        begin
            n_rec    = $urandom_range(1, 4);
            ctr_at   = ($urandom_range(99) < 90) ? $urandom_range(n_rec - 1) : -1;
            ctr_also = ($urandom_range(99) < 12) ? $urandom_range(n_rec - 1) : -1;
            for (int i = 0; i < n_rec; i++)
            begin
                if (i == ctr_at)
                    add_counter_record(slot);
                if (i == ctr_also)
                    add_counter_record(slot);
                if (i != ctr_at && i != ctr_also)
                    add_other_record();
            end
        end
        // truncate now and then to hit the cut-off cases
        if ($urandom_range(99) < 8)
        begin
            cut = $urandom_range(1, pkt_bytes.size());
            while (pkt_bytes.size() > cut)
                void'(pkt_bytes.pop_back());
        end
        n_bytes = pkt_bytes.size();
        queue_bytes(slot);
    endtask

    task automatic queue_random_bytes(input int budget);
        int sent;
        int n;
        sent = 0;
        while (sent < budget)
        begin
            queue_packet(n);
            sent = sent + n;
        end
    endtask

    // Wait until every byte has transferred and every verdict has come back,
    // then let the block settle.
    task automatic drain_verdicts();
        while (!(body_pending.size() == 0 && !body_valid && verdicts_due.size() == 0))
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [BYTE_W-1:0] val);
        @(negedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= val;
        if (idx == CFG_PAD_TYPE)
            reg_pad = val;
        else
            reg_ctr = val;
        @(negedge clk);
        cfg_write_en <= 1'b0;
    endtask

    task automatic set_type_codes(input logic [BYTE_W-1:0] pad,
                                  input logic [BYTE_W-1:0] ctr);
        write_reg(CFG_PAD_TYPE, pad);
        write_reg(CFG_COUNTER_TYPE, ctr);
        settings_used = settings_used + 1;
    endtask

    // ------------------------------------------------------------------
    // Run sequence
    // ------------------------------------------------------------------
    initial
    begin
        for (int i = 0; i < 4; i++)
            verdict_seen[i] = 0;
        reset_model();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed packets under the reset type codes (pad 0, counter 11).
        // Body ends right after a counter type byte.
        pkt_bytes = {8'd11};
        queue_bytes(4'd0);
        // Counter record with a length too short for the value.
        pkt_bytes = {8'd11, 8'd5};
        queue_bytes(4'd0);
        // Pad byte, then a counter just above the cleared entry.
        pkt_bytes = {8'd0, 8'd11, 8'd6, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01};
        queue_bytes(4'd15);
        // Largest counter; the body ends inside the trailing data, which is fine.
        pkt_bytes = {8'd11, 8'd8, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'h33};
        queue_bytes(4'd15);
        // Same counter again: not newer, so replayed.
        pkt_bytes = {8'd11, 8'd6, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff};
        queue_bytes(4'd15);
        // Ordinary record cut inside its data, then one cut after its type.
        pkt_bytes = {8'h80, 8'd3, 8'd1};
        queue_bytes(4'd3);
        pkt_bytes = {8'hff};
        queue_bytes(4'd3);
        gen_last[15] = CTR_MAX;
        drain_verdicts();

        // Receiver holds off for a long stretch while the sender keeps
        // offering bytes, so a second verdict backs up into the input.
        @(posedge clk);
        hold_req = 250;
        queue_random_bytes(200);
        drain_verdicts();

        // Swapped extremes for the codes; no idling on either side.
        set_type_codes(8'd255, 8'd0);
        send_idle_pct = 0;
        rcv_idle_pct  = 0;
        queue_random_bytes(170);
        drain_verdicts();

        // Equal codes: the pad test wins, so no counter record can appear.
        send_idle_pct = 32;
        rcv_idle_pct  = 32;
        set_type_codes(8'h5a, 8'h5a);
        queue_random_bytes(70);
        drain_verdicts();

        set_type_codes(8'd0, 8'd255);
        queue_random_bytes(180);
        drain_verdicts();

        if (verdicts_due.size() != 0)
        begin
            $display("ERROR: %0d verdicts never arrived", verdicts_due.size());
            fail_count = fail_count + 1;
        end
        $display("Moved %0d body bytes under %0d type-code settings, with a long verdict stall",
                 bytes_moved, settings_used);
        $display("Verdicts: %0d accepted, %0d replayed, %0d count not one, %0d malformed",
                 verdict_seen[VERDICT_ACCEPT], verdict_seen[VERDICT_REPLAY],
                 verdict_seen[VERDICT_COUNT], verdict_seen[VERDICT_MALFORMED]);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #4000000;
        $display("Verification failed");
        $finish;
    end

endmodule
